/* hdl/fsmp_pkg.sv */
// ----------------------------------------------------------------------------
// fsmp_pkg: shared types and constants of the format spec modifier parser
// Character codes, flag bit positions, length codes and the classified-beat
// record that travels from the front classifier to the back parser.
// ----------------------------------------------------------------------------
package fsmp_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_ADDR_BITS = 2;

   // flag bit positions
   localparam int FLAG_COUNT = 5;
   localparam int FLAG_MINUS = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_HASH  = 3;
   localparam int FLAG_ZERO  = 4;

   // character codes
   localparam logic [7:0] CHR_MINUS  = 8'h2D;
   localparam logic [7:0] CHR_PLUS   = 8'h2B;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_LOW_H  = 8'h68;
   localparam logic [7:0] CHR_LOW_L  = 8'h6C;
   localparam logic [7:0] CHR_UP_L   = 8'h4C;
   localparam logic [7:0] CHR_LOW_J  = 8'h6A;
   localparam logic [7:0] CHR_LOW_Z  = 8'h7A;

   // length modifier codes
   typedef enum logic [2:0] {
      LEN_NONE  = 3'd0,
      LEN_HH    = 3'd1,
      LEN_H     = 3'd2,
      LEN_LL    = 3'd3,
      LEN_L     = 3'd4,
      LEN_J     = 3'd5,
      LEN_Z     = 3'd6,
      LEN_BIG_L = 3'd7
   } length_type;

   // classified character
   typedef struct packed {
      logic [FLAG_COUNT-1:0] flag_mask;
      logic                  is_star;
      logic                  is_digit;
      logic [3:0]            digit;
      logic                  is_dot;
      length_type            len_kind;
      logic                  negative;
      logic [7:0]            chr;
   } char_class_type;

   localparam int CLASS_BITS = $bits(char_class_type);

endpackage

/* hdl/fsmp_front.sv */
// ----------------------------------------------------------------------------
// fsmp_front: input classifier
// Accepts request beats, sorts each character into its classes and takes
// the saturated magnitude of the star argument, then pushes the queue.
// ----------------------------------------------------------------------------
module fsmp_front
   import fsmp_pkg::*;
#(
   parameter int FIELD_BITS = 16
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_character,
   input  logic signed [31:0]    req_star_value,
   input  logic                  q_full,
   output logic                  q_push,
   output char_class_type        q_class,
   output logic [FIELD_BITS-1:0] q_star_sat
);

   localparam logic [32:0] FIELD_MAX = (33'd1 << FIELD_BITS) - 33'd1;

   logic        negative;
   logic [31:0] magnitude;

   // stall while the queue is full
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // absolute value of the star argument, saturated to the field
   assign negative   = req_star_value[31];
   assign magnitude  = negative ? (~req_star_value + 32'd1) : req_star_value;
   assign q_star_sat = ({1'b0, magnitude} > FIELD_MAX) ? FIELD_MAX[FIELD_BITS-1:0]
                                                       : magnitude[FIELD_BITS-1:0];

   // classify the character
   always_comb begin
      q_class          = '0;
      q_class.chr      = req_character;
      q_class.negative = negative;
      q_class.flag_mask[FLAG_MINUS] = (req_character == CHR_MINUS);
      q_class.flag_mask[FLAG_PLUS]  = (req_character == CHR_PLUS);
      q_class.flag_mask[FLAG_SPACE] = (req_character == CHR_SPACE);
      q_class.flag_mask[FLAG_HASH]  = (req_character == CHR_HASH);
      q_class.flag_mask[FLAG_ZERO]  = (req_character == CHR_ZERO);
      q_class.is_star  = (req_character == CHR_STAR);
      q_class.is_dot   = (req_character == CHR_DOT);
      q_class.is_digit = (req_character >= CHR_ZERO) && (req_character <= CHR_NINE);
      q_class.digit    = req_character[3:0];
      unique case (req_character)
         CHR_LOW_H: q_class.len_kind = LEN_H;
         CHR_LOW_L: q_class.len_kind = LEN_L;
         CHR_LOW_J: q_class.len_kind = LEN_J;
         CHR_LOW_Z: q_class.len_kind = LEN_Z;
         CHR_UP_L:  q_class.len_kind = LEN_BIG_L;
         default:   q_class.len_kind = LEN_NONE;
      endcase
   end

endmodule

/* hdl/fsmp_queue.sv */
// ----------------------------------------------------------------------------
// fsmp_queue: short FIFO between classifier and parser
// Holds classified beats so that front and back stall independently.
// ----------------------------------------------------------------------------
module fsmp_queue
   import fsmp_pkg::*;
#(
   parameter int DATA_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] head_data
);

   logic [DATA_BITS-1:0]     store_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_BITS:0] rd_ptr_ff, rd_ptr_in;

   // occupancy from pointer comparison
   assign not_empty = (wr_ptr_ff != rd_ptr_ff);
   assign full      = (wr_ptr_ff[QUEUE_ADDR_BITS] != rd_ptr_ff[QUEUE_ADDR_BITS]) &&
                      (wr_ptr_ff[QUEUE_ADDR_BITS-1:0] == rd_ptr_ff[QUEUE_ADDR_BITS-1:0]);
   assign head_data = store_ff[rd_ptr_ff[QUEUE_ADDR_BITS-1:0]];

   // advance pointers
   assign wr_ptr_in = wr_ptr_ff + {{QUEUE_ADDR_BITS{1'b0}}, push};
   assign rd_ptr_in = rd_ptr_ff + {{QUEUE_ADDR_BITS{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff[QUEUE_ADDR_BITS-1:0]] <= push_data;
      end
   end

endmodule

/* hdl/fsmp_back.sv */
// ----------------------------------------------------------------------------
// fsmp_back: phase parser and result register
// Pops classified beats, advances the flag, width, precision and length
// phases, and loads the result register on the specifier.
// ----------------------------------------------------------------------------
module fsmp_back
   import fsmp_pkg::*;
#(
   parameter int FIELD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  char_class_type        q_class,
   input  logic [FIELD_BITS-1:0] q_star_sat,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_left_align,
   output logic                  rsp_force_sign,
   output logic                  rsp_space_sign,
   output logic                  rsp_alternate_form,
   output logic                  rsp_zero_pad,
   output logic [FIELD_BITS-1:0] rsp_field_width,
   output logic                  rsp_precision_given,
   output logic [FIELD_BITS-1:0] rsp_precision_value,
   output logic [2:0]            rsp_length_code,
   output logic [7:0]            rsp_specifier,
   output logic [7:0]            rsp_consumed_count
);

   typedef enum logic [2:0] {
      PH_FLAGS    = 3'd0,
      PH_W_STAR   = 3'd1,
      PH_W_DIGITS = 3'd2,
      PH_W_FROZEN = 3'd3,
      PH_P_START  = 3'd4,
      PH_P_DIGITS = 3'd5,
      PH_P_STAR   = 3'd6,
      PH_LENGTH   = 3'd7
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [FLAG_COUNT-1:0] flags_ff, flags_in;
   logic [FIELD_BITS-1:0] width_ff, width_in;
   logic                  pseen_ff, pseen_in;
   logic [FIELD_BITS-1:0] prec_ff, prec_in;
   length_type            len_ff, len_in;
   logic [1:0]            lseen_ff, lseen_in;
   logic [7:0]            count_ff, count_in;
   logic                  consumed;
   logic                  out_free;
   logic                  in_width;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FLAG_COUNT-1:0] rsp_flags_ff;
   logic [FIELD_BITS-1:0] rsp_width_ff;
   logic                  rsp_pseen_ff;
   logic [FIELD_BITS-1:0] rsp_prec_ff;
   length_type            rsp_len_ff;
   logic [7:0]            rsp_spec_ff;
   logic [7:0]            rsp_count_ff;

   // multiply by ten, add a digit, saturate
   function automatic logic [FIELD_BITS-1:0] acc10(input logic [FIELD_BITS-1:0] acc,
                                                   input logic [3:0] dig);
      logic [FIELD_BITS+3:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{FIELD_BITS{1'b0}}, dig};
      return (|wide[FIELD_BITS+3:FIELD_BITS]) ? {FIELD_BITS{1'b1}} : wide[FIELD_BITS-1:0];
   endfunction

   assign in_width = (phase_ff == PH_FLAGS) || (phase_ff == PH_W_STAR) ||
                     (phase_ff == PH_W_DIGITS) || (phase_ff == PH_W_FROZEN);

   // phase decision for the head beat
   always_comb begin
      phase_in = phase_ff;
      flags_in = flags_ff;
      width_in = width_ff;
      pseen_in = pseen_ff;
      prec_in  = prec_ff;
      len_in   = len_ff;
      lseen_in = lseen_ff;
      consumed = 1'b1;
      priority if ((phase_ff == PH_FLAGS) && (|q_class.flag_mask)) begin
         flags_in = flags_ff | q_class.flag_mask;
      end else if ((phase_ff == PH_FLAGS) && q_class.is_star) begin
         width_in = q_star_sat;
         if (q_class.negative) flags_in[FLAG_MINUS] = 1'b1;
         phase_in = PH_W_STAR;
      end else if (((phase_ff == PH_FLAGS) || (phase_ff == PH_W_STAR)) &&
                   q_class.is_digit) begin
         width_in = acc10('0, q_class.digit);
         phase_in = PH_W_DIGITS;
      end else if ((phase_ff == PH_W_STAR) && q_class.is_star) begin
         phase_in = PH_W_STAR;
      end else if ((phase_ff == PH_W_DIGITS) && q_class.is_digit) begin
         width_in = acc10(width_ff, q_class.digit);
      end else if (((phase_ff == PH_W_DIGITS) || (phase_ff == PH_W_FROZEN)) &&
                   (q_class.is_star || q_class.is_digit)) begin
         phase_in = PH_W_FROZEN;
      end else if (in_width && q_class.is_dot) begin
         pseen_in = 1'b1;
         prec_in  = '0;
         phase_in = PH_P_START;
      end else if (((phase_ff == PH_P_START) || (phase_ff == PH_P_DIGITS)) &&
                   q_class.is_digit) begin
         prec_in  = acc10(prec_ff, q_class.digit);
         phase_in = PH_P_DIGITS;
      end else if ((phase_ff == PH_P_START) && q_class.is_star) begin
         if (q_class.negative) begin
            pseen_in = 1'b0;
         end else begin
            prec_in = q_star_sat;
         end
         phase_in = PH_P_STAR;
      end else if ((phase_ff == PH_P_STAR) && q_class.is_star) begin
         phase_in = PH_P_STAR;
      end else if (q_class.len_kind != LEN_NONE) begin
         if (phase_ff != PH_LENGTH) begin
            len_in   = q_class.len_kind;
            lseen_in = 2'd1;
            phase_in = PH_LENGTH;
         end else begin
            if (lseen_ff == 2'd1) begin
               if ((len_ff == LEN_H) && (q_class.chr == CHR_LOW_H)) len_in = LEN_HH;
               if ((len_ff == LEN_L) && (q_class.chr == CHR_LOW_L)) len_in = LEN_LL;
            end
            if (lseen_ff != 2'd3) lseen_in = lseen_ff + 2'd1;
         end
      end else begin
         consumed = 1'b0;
      end
   end

   // pop consumed beats freely, the specifier only into a free result slot
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = q_not_empty && (consumed || out_free);
   assign count_in = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

   // load on a popped specifier, hold while the result beat is stalled
   assign rsp_valid_in = (q_pop && !consumed) || (rsp_valid_ff && !out_free);

   // hold parse state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAGS;
         flags_ff     <= '0;
         width_ff     <= '0;
         pseen_ff     <= 1'b0;
         prec_ff      <= '0;
         len_ff       <= LEN_NONE;
         lseen_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            if (consumed) begin
               phase_ff <= phase_in;
               flags_ff <= flags_in;
               width_ff <= width_in;
               pseen_ff <= pseen_in;
               prec_ff  <= prec_in;
               len_ff   <= len_in;
               lseen_ff <= lseen_in;
               count_ff <= count_in;
            end else begin
               // emit the record and start the next spec
               rsp_flags_ff <= flags_ff;
               rsp_width_ff <= width_ff;
               rsp_pseen_ff <= pseen_ff;
               rsp_prec_ff  <= pseen_ff ? prec_ff : '0;
               rsp_len_ff   <= len_ff;
               rsp_spec_ff  <= q_class.chr;
               rsp_count_ff <= count_ff;
               phase_ff     <= PH_FLAGS;
               flags_ff     <= '0;
               width_ff     <= '0;
               pseen_ff     <= 1'b0;
               prec_ff      <= '0;
               len_ff       <= LEN_NONE;
               lseen_ff     <= '0;
               count_ff     <= '0;
            end
         end
      end
   end

   // drive the result beat
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_align      = rsp_flags_ff[FLAG_MINUS];
   assign rsp_force_sign      = rsp_flags_ff[FLAG_PLUS];
   assign rsp_space_sign      = rsp_flags_ff[FLAG_SPACE] && !rsp_flags_ff[FLAG_PLUS];
   assign rsp_alternate_form  = rsp_flags_ff[FLAG_HASH];
   assign rsp_zero_pad        = rsp_flags_ff[FLAG_ZERO];
   assign rsp_field_width     = rsp_width_ff;
   assign rsp_precision_given = rsp_pseen_ff;
   assign rsp_precision_value = rsp_prec_ff;
   assign rsp_length_code     = rsp_len_ff;
   assign rsp_specifier       = rsp_spec_ff;
   assign rsp_consumed_count  = rsp_count_ff;

endmodule

/* hdl/format_spec_modifier_parser.sv */
// ----------------------------------------------------------------------------
// format_spec_modifier_parser: printf-style conversion spec parser
// Parses flags, width, precision and length modifier of one conversion spec
// and returns the full record when the specifier character arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_): one beat per character that follows the percent
//   sign, with the star argument alongside; it is used only when the
//   character is a star in the width or precision position.
//   Response channel (rsp_): one beat per spec, on its specifier character.
//   Throughput is one character per cycle while req_stall is low, set by the
//   phase update (multiply-by-ten accumulate) in the parser.
//   A specifier is written into the four-entry queue and then loaded into
//   the result register, where rsp_valid rises; it can wait in either.
//   While rsp_stall is high, modifier characters keep flowing; the next
//   specifier waits at the queue head and req_stall rises once the queue
//   fills.
//   Reset clears the queue and the parse state and drops any pending result.
//   Width and precision saturate at 2**FIELD_BITS - 1.
// ----------------------------------------------------------------------------
module format_spec_modifier_parser
   import fsmp_pkg::*;
#(
   parameter int FIELD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_character,
   input  logic signed [31:0]    req_star_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_left_align,
   output logic                  rsp_force_sign,
   output logic                  rsp_space_sign,
   output logic                  rsp_alternate_form,
   output logic                  rsp_zero_pad,
   output logic [FIELD_BITS-1:0] rsp_field_width,
   output logic                  rsp_precision_given,
   output logic [FIELD_BITS-1:0] rsp_precision_value,
   output logic [2:0]            rsp_length_code,
   output logic [7:0]            rsp_specifier,
   output logic [7:0]            rsp_consumed_count
);

   localparam int ENTRY_BITS = CLASS_BITS + FIELD_BITS;

   logic                  q_full;
   logic                  q_push;
   char_class_type        push_class;
   logic [FIELD_BITS-1:0] push_sat;
   logic                  q_pop;
   logic                  q_not_empty;
   logic [ENTRY_BITS-1:0] head_data;
   char_class_type        head_class;
   logic [FIELD_BITS-1:0] head_sat;

   fsmp_front #(.FIELD_BITS(FIELD_BITS)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_star_value (req_star_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_class        (push_class),
      .q_star_sat     (push_sat)
   );

   fsmp_queue #(.DATA_BITS(ENTRY_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_class, push_sat}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (head_data)
   );

   // split the queue head
   assign head_class = char_class_type'(head_data[ENTRY_BITS-1:FIELD_BITS]);
   assign head_sat   = head_data[FIELD_BITS-1:0];

   fsmp_back #(.FIELD_BITS(FIELD_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_not_empty         (q_not_empty),
      .q_class             (head_class),
      .q_star_sat          (head_sat),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_align      (rsp_left_align),
      .rsp_force_sign      (rsp_force_sign),
      .rsp_space_sign      (rsp_space_sign),
      .rsp_alternate_form  (rsp_alternate_form),
      .rsp_zero_pad        (rsp_zero_pad),
      .rsp_field_width     (rsp_field_width),
      .rsp_precision_given (rsp_precision_given),
      .rsp_precision_value (rsp_precision_value),
      .rsp_length_code     (rsp_length_code),
      .rsp_specifier       (rsp_specifier),
      .rsp_consumed_count  (rsp_consumed_count)
   );

endmodule
